FILE: hdl/rgba_half_downsample_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGBA half-size downsampler
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGBA_HALF_DOWNSAMPLE_TOP_DEFINES_SVH
`define RGBA_HALF_DOWNSAMPLE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rhd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RHD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rhd assertion failed");

`endif

FILE: hdl/rhd_pkg.sv
// ----------------------------------------------------------------------------
// RGBA half-size downsampler package
// Payload types, lane control struct, register codes and widths.
// ----------------------------------------------------------------------------
package rhd_pkg;

  localparam int CH_W          = 8;
  localparam int PSUM_W        = CH_W + 1;
  localparam int NUM_LANES     = 4;
  localparam int LINE_W        = NUM_LANES * PSUM_W;
  localparam int WIDTH_REG_W   = 13;
  localparam int HEIGHT_W      = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int DEF_MAX_WIDTH = 4096;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
    logic            final_pixel;
  } result_t;

  typedef struct packed {
    logic take_left;  // even column: capture the left pixel of the pair
    logic w_one;      // one-pixel-wide source
    logic h_one;      // one-pixel-high source
    logic s1_load;    // an emitting transaction enters the second stage
  } lane_ctl_t;

endpackage

FILE: hdl/rhd_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module rhd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/rhd_lane.sv
// ----------------------------------------------------------------------------
// RGBA half-size downsampler channel lane
// Horizontal pair sum, vertical completion and divide by four for one channel.
// ----------------------------------------------------------------------------
module rhd_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  rhd_pkg::lane_ctl_t       ctl,
  input  logic [rhd_pkg::CH_W-1:0] chan,
  input  logic [rhd_pkg::PSUM_W-1:0] line_q,
  output logic [rhd_pkg::PSUM_W-1:0] hsum,
  output logic [rhd_pkg::CH_W-1:0] avg
);

  import rhd_pkg::*;

  logic [CH_W-1:0]   held;
  logic [PSUM_W-1:0] hsum1;
  logic [PSUM_W:0]   total;

  always_comb begin
    if (ctl.w_one) begin
      hsum = {chan, 1'b0};
    end else begin
      hsum = PSUM_W'(held) + PSUM_W'(chan);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctl.take_left) begin
      held <= chan;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      hsum1 <= hsum;
    end
  end

  // A one-row source counts each pair sum for both rows.
  always_comb begin
    if (ctl.h_one) begin
      total = {hsum1, 1'b0};
    end else begin
      total = (PSUM_W+1)'(hsum1) + (PSUM_W+1)'(line_q);
    end
  end

  assign avg = total[PSUM_W:2];

endmodule

FILE: hdl/rgba_half_downsample_top.sv
// ----------------------------------------------------------------------------
// RGBA half-size downsampler
// 2x2 box-filter mipmap reduction of a raster RGBA8 stream, four channel lanes.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                               Direction  Flow control
//   pixel    pix_valid, pix_stall, pix             in         valid / stall
//   result   res_valid, res_stall, res             out        valid / stall
//   config   cfg_valid, cfg_ready, cfg_index/data  in         valid / ready
//
// One source pixel is taken every clock unless the result side stalls. The
// pixel that completes a 2x2 square passes the second-stage register, which
// waits on the line store's registered read, and then the output register.
// Reset is synchronous and needs no clearing pass: the line store is always
// written on an even row before the odd row reads it. A stall on the result
// side holds the whole pipeline and stalls the pixel side in the same cycle.
// ----------------------------------------------------------------------------
`include "rgba_half_downsample_top_defines.svh"

module rgba_half_downsample_top #(
  parameter int MAX_WIDTH = rhd_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pix_valid,
  output logic                            pix_stall,
  input  rhd_pkg::pixel_t                 pix,
  output logic                            res_valid,
  input  logic                            res_stall,
  output rhd_pkg::result_t                res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rhd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rhd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import rhd_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;

  // Configuration registers.
  logic [WIDTH_REG_W-1:0] source_width;
  logic [HEIGHT_W-1:0]    source_height;
  logic                   cfg_write;

  // Raster position of the next source pixel.
  logic [CW-1:0]          col;
  logic [HEIGHT_W-1:0]    row;

  logic [WW-1:0]          w_eff;
  logic [HEIGHT_W-1:0]    h_eff;
  logic [CW-1:0]          w_last;
  logic [HEIGHT_W-1:0]    h_last;
  logic                   w_one;
  logic                   h_one;

  logic                   advance;
  logic                   accept;
  logic                   have_pair;
  logic                   emit0;
  logic                   store0;
  logic                   x_last;
  logic                   y_last;
  logic [IW-1:0]          line_idx;

  logic                   s1_valid;
  logic                   final1;

  lane_ctl_t              ctl;
  logic [CH_W-1:0]        chan   [NUM_LANES];
  logic [CH_W-1:0]        avg    [NUM_LANES];
  logic [LINE_W-1:0]      line_wd;
  logic [LINE_W-1:0]      line_q;

  // The configuration port is always ready; writes must come only while idle, which the block leaves to the user.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready &&
                     ((cfg_index == REG_SOURCE_WIDTH) || (cfg_index == REG_SOURCE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= WIDTH_REG_W'(1);
      source_height <= HEIGHT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[HEIGHT_W-1:0];
        default:           ;
      endcase
    end
  end

  // A zero width or height acts as one; a width above the line store saturates.
  always_comb begin
    if (source_width == '0) begin
      w_eff = WW'(1);
    end else if (CMPW'(source_width) > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(source_width);
    end
    h_eff  = (source_height == '0) ? HEIGHT_W'(1) : source_height;
    w_last = CW'(w_eff - WW'(1));
    h_last = h_eff - HEIGHT_W'(1);
    w_one  = (w_eff == WW'(1));
    h_one  = (h_eff == HEIGHT_W'(1));
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign advance   = !res_valid || !res_stall;
  assign pix_stall = !advance;
  assign accept    = pix_valid && !pix_stall;

  // An odd column closes a horizontal pair; an odd row closes the square.
  assign have_pair = w_one || col[0];
  assign emit0     = have_pair && (h_one || row[0]);
  assign store0    = have_pair && !h_one && !row[0];
  assign line_idx  = IW'(col >> 1);

  // Last column and row of the reduced image.
  assign x_last = w_one || ((col >> 1) == CW'((w_eff >> 1) - WW'(1)));
  assign y_last = h_one || ((row >> 1) == ((h_eff >> 1) - HEIGHT_W'(1)));

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + HEIGHT_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  assign ctl.take_left = accept && !w_one && !col[0];
  assign ctl.w_one     = w_one;
  assign ctl.h_one     = h_one;
  assign ctl.s1_load   = accept && emit0;

  assign chan[0] = pix.red;
  assign chan[1] = pix.green;
  assign chan[2] = pix.blue;
  assign chan[3] = pix.alpha;

  // Four channel lanes share the control and one word of the line store.
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rhd_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .chan   (chan[i]),
      .line_q (line_q[i*PSUM_W +: PSUM_W]),
      .hsum   (line_wd[i*PSUM_W +: PSUM_W]),
      .avg    (avg[i])
    );
  end

  // Even rows write pair sums; the odd row reads them back at the same index.
  rhd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (accept && store0),
    .wr_addr (line_idx),
    .wr_data (line_wd),
    .rd_en   (ctl.s1_load),
    .rd_addr (line_idx),
    .rd_data (line_q)
  );

  // Second stage: the line store read is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && emit0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      final1 <= x_last && y_last;
    end
  end

  // Merge stage: the lanes' averages and the end mark form one transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res.out_red     <= avg[0];
      res.out_green   <= avg[1];
      res.out_blue    <= avg[2];
      res.out_alpha   <= avg[3];
      res.final_pixel <= final1;
    end
  end

  // A blocked result must hold back the pixel side.
  `RHD_ASSERT_SAME(a_stall_back, res_valid && res_stall, pix_stall)
  // A second-stage transaction reaches the output register once the pipe moves.
  `RHD_ASSERT_NEXT(a_s1_to_out, s1_valid && advance, res_valid)
  // The column counter never runs past the configured width.
  `RHD_ASSERT_SAME(a_col_range, !cfg_write, col <= w_last)
  // A register write returns the raster position to the image start.
  `RHD_ASSERT_NEXT(a_cfg_home, cfg_write, col == '0 && row == '0)

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the RGBA half-size downsampler
// Streams RGBA8 source images of many sizes through the block, predicts each
// 2x2 box-filtered result in a scoreboard, and checks every result transaction
// field by field under varying source and sink throttling.
// ----------------------------------------------------------------------------
module testbench;
  import rhd_pkg::*;

  localparam int MAX_W           = DEF_MAX_WIDTH;
  localparam int LINE_DEPTH      = MAX_W / 2;
  // The result passes the second-stage and output registers after the pixel
  // that completes it, so this pad is plenty to let the pipeline settle.
  localparam int LATENCY_PAD     = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RANDOM_ITEMS    = 520;

  // Indexes past the register list; writes to them must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  // Predicts the reduced image from the accepted source pixels and holds the
  // results still owed by the block, oldest first.
  class mip_scoreboard;
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    int unsigned            pair_sums [LINE_DEPTH][4];
    int unsigned            left_px [4];
    int unsigned            col_pos;
    int unsigned            row_pos;
    result_t                owed_q [$];
    int unsigned            errors;

    function new();
      width_reg  = 1;
      height_reg = 1;
      col_pos    = 0;
      row_pos    = 0;
      errors     = 0;
      foreach (left_px[k]) left_px[k] = 0;
    endfunction

    // Register writes restart the image; unknown indexes leave everything alone.
    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_SOURCE_WIDTH) begin
        width_reg = val[WIDTH_REG_W-1:0];
      end else if (idx == REG_SOURCE_HEIGHT) begin
        height_reg = val;
      end else begin
        return;
      end
      col_pos = 0;
      row_pos = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void note_pixel(pixel_t p);
      int unsigned w, h, slot, rw, rh, ox, oy;
      int unsigned px [4];
      int unsigned hsum [4];
      int unsigned total [4];
      bit          paired;
      bit          fire;
      result_t     r;
      w = (width_reg == 0) ? 1 : width_reg;
      if (w > MAX_W) w = MAX_W;
      h = (height_reg == 0) ? 1 : height_reg;
      px[0] = p.red;
      px[1] = p.green;
      px[2] = p.blue;
      px[3] = p.alpha;
      paired = 0;
      fire   = 0;

      // Horizontal pairing: a one-pixel-wide image pairs each pixel with itself.
      if (w == 1) begin
        foreach (hsum[k]) hsum[k] = 2 * px[k];
        paired = 1;
      end else if (col_pos % 2 == 0) begin
        foreach (left_px[k]) left_px[k] = px[k];
      end else begin
        foreach (hsum[k]) hsum[k] = left_px[k] + px[k];
        paired = 1;
      end

      // Vertical pairing through the line store of even-row sums.
      if (paired) begin
        slot = (col_pos / 2) % LINE_DEPTH;
        if (h == 1) begin
          foreach (total[k]) total[k] = 2 * hsum[k];
          fire = 1;
        end else if (row_pos % 2 == 0) begin
          foreach (hsum[k]) pair_sums[slot][k] = hsum[k];
        end else begin
          foreach (total[k]) total[k] = pair_sums[slot][k] + hsum[k];
          fire = 1;
        end
      end

      if (fire) begin
        rw = (w / 2 == 0) ? 1 : w / 2;
        rh = (h / 2 == 0) ? 1 : h / 2;
        ox = (w == 1) ? 0 : col_pos / 2;
        oy = (h == 1) ? 0 : row_pos / 2;
        r.out_red     = 8'(total[0] / 4);
        r.out_green   = 8'(total[1] / 4);
        r.out_blue    = 8'(total[2] / 4);
        r.out_alpha   = 8'(total[3] / 4);
        r.final_pixel = (ox == rw - 1) && (oy == rh - 1);
        owed_q = {owed_q, r};
      end

      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result with none expected, got %p", $time, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("out_red", want.out_red, got.out_red);
      compare_field("out_green", want.out_green, got.out_green);
      compare_field("out_blue", want.out_blue, got.out_blue);
      compare_field("out_alpha", want.out_alpha, got.out_alpha);
      compare_field("final_pixel", want.final_pixel, got.final_pixel);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   pix_valid;
  logic                   pix_stall;
  pixel_t                 pix;
  logic                   res_valid;
  logic                   res_stall;
  result_t                res;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mip_scoreboard sb = new();

  // Throttling knobs, in percent of cycles, changed from phase to phase.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // Cycles the sink still has to hold off; counted down by the sink process.
  int hold_left     = 0;
  int quiet_cycles  = 0;

  rgba_half_downsample_top #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sink side: the stall changes on the falling edge. A requested hold-off
  // keeps it high for a long stretch so that the block backs up into the
  // pixel channel; otherwise it stalls at random at the phase's rate.
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Every result transaction is checked against the oldest prediction.
  // Sampling at the rising edge sees the values the block itself sees.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res);
  end

  // Watchdog: a run that stops moving transactions for too long has hung.
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one pixel, with random idle cycles ahead of it, and holds it until
  // the block takes it. The valid stays high into the next call, so a
  // back-to-back stream sees exactly one assignment per falling edge.
  task automatic send_pixel(input pixel_t p);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= p;
    do @(posedge clk); while (pix_stall);
    sb.note_pixel(p);
  endtask

  // Stops the pixel stream and waits until every owed result has arrived,
  // then lets the pipeline settle, since a trailing pixel may give no result.
  task automatic drain();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic pixel_t mk_pixel(int r, int g, int b, int a);
    pixel_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    p.alpha = 8'(a);
    return p;
  endfunction

  // Channel values lean toward the extremes now and then.
  function automatic logic [7:0] rand_chan();
    int s;
    s = $urandom_range(9);
    if (s == 0) return 8'h00;
    if (s == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic pixel_t rand_pixel();
    return mk_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
  endfunction

  initial begin
    int send_pcts [4];
    int stall_pcts [4];
    int phase_items;
    int sel;
    int w;
    int h;
    int ew;
    int eh;
    int count;
    logic [CFG_DATA_W-1:0] wdata;

    send_pcts  = '{0, 49, 0, 33};
    stall_pcts = '{0, 0, 49, 33};
    rst       = 1'b1;
    pix_valid = 1'b0;
    pix       = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed part. The reset size is one by one, so each pixel is a whole
    // image and comes back unchanged with the last-pixel flag set.
    send_pixel(mk_pixel(255, 255, 255, 255));
    send_pixel(mk_pixel(0, 0, 0, 0));
    send_pixel(mk_pixel(1, 2, 128, 254));

    // A single 2x2 square: full-scale sums and truncation of the mean.
    write_reg(REG_SOURCE_WIDTH, 16'd2);
    write_reg(REG_SOURCE_HEIGHT, 16'd2);
    send_pixel(mk_pixel(255, 0, 255, 3));
    send_pixel(mk_pixel(255, 0, 0, 2));
    send_pixel(mk_pixel(255, 0, 255, 1));
    send_pixel(mk_pixel(255, 0, 254, 1));

    // Odd width and odd height: the last column and last row are dropped.
    write_reg(REG_SOURCE_WIDTH, 16'd3);
    write_reg(REG_SOURCE_HEIGHT, 16'd3);
    repeat (9) send_pixel(rand_pixel());

    // Zero sizes behave as a size of one.
    write_reg(REG_SOURCE_WIDTH, 16'd0);
    write_reg(REG_SOURCE_HEIGHT, 16'd0);
    send_pixel(rand_pixel());

    // One row high: each pair sum counts for both rows.
    write_reg(REG_SOURCE_WIDTH, 16'd2);
    write_reg(REG_SOURCE_HEIGHT, 16'd1);
    repeat (2) send_pixel(rand_pixel());

    // One column wide: each pixel pairs with itself.
    write_reg(REG_SOURCE_WIDTH, 16'd1);
    write_reg(REG_SOURCE_HEIGHT, 16'd2);
    repeat (2) send_pixel(rand_pixel());

    // Writes to unused indexes in mid-image must not restart the image.
    write_reg(REG_SOURCE_WIDTH, 16'd2);
    write_reg(REG_SOURCE_HEIGHT, 16'd2);
    repeat (2) send_pixel(rand_pixel());
    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'h5A5A);
    repeat (2) send_pixel(rand_pixel());

    // Random part, in four throttling phases. Most images are small and run
    // to completion, some once or twice over, some cut short by the next
    // register write.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pcts[ph];
      stall_pct     = stall_pcts[ph];
      phase_items   = 0;

      // Back-pressure: the sink holds off while the source keeps offering
      // pixels, so the block fills up and stalls the pixel channel.
      if (ph == 0) begin
        write_reg(REG_SOURCE_WIDTH, 16'd2);
        write_reg(REG_SOURCE_HEIGHT, 16'd1);
        hold_left = HOLD_OFF_CYCLES;
        repeat (80) send_pixel(rand_pixel());
        phase_items = 80;
      end

      while (phase_items < RANDOM_ITEMS / 4) begin
        sel = $urandom_range(99);
        if (sel < 75) w = $urandom_range(1, 8);
        else if (sel < 90) w = $urandom_range(9, 40);
        else w = 0;
        // The bits above the width field are ignored by the block.
        wdata = CFG_DATA_W'(w);
        if ($urandom_range(3) == 0) wdata[CFG_DATA_W-1:WIDTH_REG_W] = 3'($urandom);

        sel = $urandom_range(99);
        if (sel < 80) h = $urandom_range(1, 6);
        else if (sel < 92) h = $urandom_range(7, 20);
        else h = 0;

        ew = (w == 0) ? 1 : w;
        eh = (h == 0) ? 1 : h;
        count = ew * eh * $urandom_range(1, 2);
        if (count > 150) count = $urandom_range(20, 150);
        else if ($urandom_range(4) == 0) count = $urandom_range(1, count);

        write_reg(REG_SOURCE_WIDTH, wdata);
        write_reg(REG_SOURCE_HEIGHT, CFG_DATA_W'(h));
        if ($urandom_range(9) == 0) begin
          write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
        end
        repeat (count) send_pixel(rand_pixel());
        phase_items += count;
      end
    end

    // Largest sizes, kept short: an all-ones width saturates to the line
    // store's limit, the exact limit follows, then the tallest height.
    write_reg(REG_SOURCE_WIDTH, 16'hFFFF);
    write_reg(REG_SOURCE_HEIGHT, 16'd1);
    repeat (64) send_pixel(rand_pixel());
    write_reg(REG_SOURCE_WIDTH, CFG_DATA_W'(MAX_W));
    repeat (20) send_pixel(rand_pixel());
    write_reg(REG_SOURCE_WIDTH, 16'd2);
    write_reg(REG_SOURCE_HEIGHT, 16'hFFFF);
    repeat (40) send_pixel(rand_pixel());
    write_reg(REG_SOURCE_WIDTH, 16'd1);
    repeat (30) send_pixel(rand_pixel());

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
